>>> rtl/core/key_event_tlv_parser_defines.svh
// Assertion helpers for the key event parser
`ifndef KEY_EVENT_TLV_PARSER_DEFINES_SVH
`define KEY_EVENT_TLV_PARSER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define KEVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define KEVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/kevt_pkg.sv
`timescale 1ns / 1ps

package kevt_pkg;

  localparam int unsigned CountW   = 9;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;

  localparam logic [CountW-1:0] CountMax = 9'd511;
  localparam logic [7:0] MinPayloadReset = 8'd1;

  localparam logic [0:0] RegMinPayload = 1'b0;

  localparam logic [7:0] TypeWheel = 8'h07;
  localparam logic [7:0] TypeStick = 8'h08;
  localparam logic [7:0] LenButton = 8'd1;
  localparam logic [7:0] LenWheel  = 8'd5;
  localparam logic [7:0] LenStick  = 8'd4;

  localparam logic [1:0] FailNone     = 2'd0;
  localparam logic [1:0] FailShort    = 2'd1;
  localparam logic [1:0] FailBadLen   = 2'd2;
  localparam logic [1:0] FailTruncate = 2'd3;

  localparam logic [3:0] EventNone   = 4'd0;
  localparam logic [3:0] EventSwitch = 4'd11;

  typedef enum logic [5:0] {
    PhHeader = 6'b000001,
    PhType   = 6'b000010,
    PhLen    = 6'b000100,
    PhValue  = 6'b001000,
    PhSkip   = 6'b010000,
    PhDead   = 6'b100000
  } phase_t;

  function automatic logic is_button(input logic [7:0] t);
    is_button = (t inside {[8'd1:8'd6]}) || (t inside {[8'd9:8'd13]});
  endfunction

  function automatic logic [7:0] record_total(input logic [7:0] t);
    if (t == TypeWheel) begin
      record_total = LenWheel;
    end else if (t == TypeStick) begin
      record_total = LenStick;
    end else begin
      record_total = LenButton;
    end
  endfunction

  function automatic logic [3:0] button_event(input logic [7:0] t, input logic [7:0] clicks,
                                              input logic [3:0] cur);
    logic [7:0] code;
    code = 8'd0;
    button_event = cur;
    if (clicks == 8'd1) begin
      if (t inside {[8'd2:8'd6]}) begin
        code = t - 8'd1;
        button_event = code[3:0];
      end else if (t inside {[8'd9:8'd13]}) begin
        code = t - 8'd3;
        button_event = code[3:0];
      end
    end else if (clicks == 8'd3) begin
      if (t == 8'd5) button_event = EventSwitch;
    end
  endfunction

endpackage

>>> rtl/core/kevt_if.sv
`timescale 1ns / 1ps

interface kevt_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface kevt_report_if;
  logic               valid;
  logic               ready;
  logic               parse_ok;
  logic [1:0]         fail_code;
  logic [3:0]         event_code;
  logic signed [15:0] stick_x;
  logic signed [15:0] stick_y;
  logic signed [15:0] wheel_degree;
  logic signed [15:0] wheel_speed;
  logic [7:0]         wheel_speed_ratio;

  modport source (output valid, output parse_ok, output fail_code, output event_code,
                  output stick_x, output stick_y, output wheel_degree, output wheel_speed,
                  output wheel_speed_ratio, input ready);
  modport sink (input valid, input parse_ok, input fail_code, input event_code,
                input stick_x, input stick_y, input wheel_degree, input wheel_speed,
                input wheel_speed_ratio, output ready);
endinterface

>>> rtl/core/key_event_tlv_parser.sv
`timescale 1ns / 1ps
// Key event TLV parser.
// Channel frame (valid/ready) carries one frame byte per beat with a last-byte
// mark. The first two bytes of each frame are header; the rest are TLV records
// for buttons, the wheel and the stick. Channel report carries one beat per
// frame, issued for the beat that has last_byte set: status plus the kept
// event, stick and wheel values after that frame.
// Throughput: one byte per cycle unless a report is stalled; each byte is parsed by
// one pass of logic between the parser state registers and the report register.
// The report is valid in the cycle after the last byte is taken.
// The report register decouples the sides: a byte is taken whenever the
// report register is empty or is being drained in the same cycle. While the
// receiver stalls a pending report, frame.ready stays low.
// APB port: register min_payload_bytes at address 0, written in the access
// cycle, readable at any time; pready is tied high.
// Reset (rst, synchronous): parser back to header skip, kept values cleared,
// min_payload_bytes back to 1, no report pending.
`include "key_event_tlv_parser_defines.svh"

module key_event_tlv_parser (
  input  logic                          clk,
  input  logic                          rst,
  kevt_frame_if.sink                    frame,
  kevt_report_if.source                 report,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kevt_pkg::AddrW-1:0]    paddr,
  input  logic [kevt_pkg::DataW-1:0]    pwdata,
  output logic [kevt_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [7:0] min_payload;

  kevt_pkg::phase_t          phase, phase_next;
  logic [kevt_pkg::CountW-1:0] byte_count, count_next;
  logic [7:0]                record_type, type_next;
  logic [7:0]                bytes_left, left_next;
  logic [7:0]                low_hold, hold_next;
  logic [1:0]                frame_error, err_next;
  logic [3:0]                current_event, event_next;
  logic [15:0]               stick_x, sx_next;
  logic [15:0]               stick_y, sy_next;
  logic [15:0]               wheel_degree, deg_next;
  logic [15:0]               wheel_speed, spd_next;
  logic [7:0]                wheel_ratio, ratio_next;

  logic [3:0]  keep_event;
  logic [15:0] keep_sx, keep_sy, keep_deg, keep_spd;
  logic [7:0]  keep_ratio;

  logic [3:0]  event_fin;
  logic [15:0] sx_fin, sy_fin, deg_fin, spd_fin;
  logic [7:0]  ratio_fin;

  logic        take;
  logic        short_frame;
  logic [1:0]  fail;
  logic [7:0]  total;
  logic [2:0]  idx;
  logic [15:0] word;
  logic [7:0]  b;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == kevt_pkg::RegMinPayload) ?
                  {{(kevt_pkg::DataW-8){1'b0}}, min_payload} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_payload <= kevt_pkg::MinPayloadReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == kevt_pkg::RegMinPayload) begin
      min_payload <= pwdata[7:0];
    end
  end

  assign frame.ready = !report.valid || report.ready;
  assign take = frame.valid && frame.ready;
  assign b = frame.frame_byte;
  assign total = kevt_pkg::record_total(record_type);
  assign idx = total[2:0] - bytes_left[2:0];
  assign word = {b, low_hold};

  always_comb begin
    phase_next = phase;
    count_next = (byte_count == kevt_pkg::CountMax) ? byte_count :
                 byte_count + {{(kevt_pkg::CountW-1){1'b0}}, 1'b1};
    type_next  = record_type;
    left_next  = bytes_left;
    hold_next  = low_hold;
    err_next   = frame_error;
    event_next = current_event;
    sx_next    = stick_x;
    sy_next    = stick_y;
    deg_next   = wheel_degree;
    spd_next   = wheel_speed;
    ratio_next = wheel_ratio;
    case (phase)
      kevt_pkg::PhHeader: begin
        if (count_next >= 9'd2) phase_next = kevt_pkg::PhType;
      end
      kevt_pkg::PhType: begin
        type_next  = b;
        phase_next = kevt_pkg::PhLen;
      end
      kevt_pkg::PhLen: begin
        if (kevt_pkg::is_button(record_type) || record_type == kevt_pkg::TypeWheel ||
            record_type == kevt_pkg::TypeStick) begin
          if (b != total) begin
            err_next   = kevt_pkg::FailBadLen;
            phase_next = kevt_pkg::PhDead;
          end else begin
            left_next  = total;
            phase_next = kevt_pkg::PhValue;
          end
        end else begin
          left_next  = b;
          phase_next = (b != 8'd0) ? kevt_pkg::PhSkip : kevt_pkg::PhType;
        end
      end
      kevt_pkg::PhValue: begin
        if (kevt_pkg::is_button(record_type)) begin
          event_next = kevt_pkg::button_event(record_type, b, current_event);
        end else if (record_type == kevt_pkg::TypeWheel) begin
          case (idx)
            3'd0, 3'd2: hold_next = b;
            3'd1: deg_next = word;
            3'd3: spd_next = word;
            default: ratio_next = b;
          endcase
        end else begin
          case (idx)
            3'd0, 3'd2: hold_next = b;
            3'd1: sx_next = word;
            default: sy_next = word;
          endcase
        end
        left_next = bytes_left - 8'd1;
        if (left_next == 8'd0) phase_next = kevt_pkg::PhType;
      end
      kevt_pkg::PhSkip: begin
        left_next = bytes_left - 8'd1;
        if (left_next == 8'd0) phase_next = kevt_pkg::PhType;
      end
      kevt_pkg::PhDead: begin
      end
      default: phase_next = kevt_pkg::PhHeader;
    endcase

    short_frame = {1'b0, count_next} < ({2'b00, min_payload} + 10'd2);
    if (short_frame) begin
      fail = kevt_pkg::FailShort;
    end else if (err_next != kevt_pkg::FailNone) begin
      fail = err_next;
    end else if (phase_next == kevt_pkg::PhLen || phase_next == kevt_pkg::PhValue ||
                 (phase_next == kevt_pkg::PhType && count_next == 9'd2)) begin
      fail = kevt_pkg::FailTruncate;
    end else begin
      fail = kevt_pkg::FailNone;
    end

    // on the last byte of a short frame, restore values from before the frame; a one-byte frame changes nothing
    if (frame.last_byte && short_frame && byte_count != '0) begin
      event_fin = keep_event;
      sx_fin    = keep_sx;
      sy_fin    = keep_sy;
      deg_fin   = keep_deg;
      spd_fin   = keep_spd;
      ratio_fin = keep_ratio;
    end else begin
      event_fin = event_next;
      sx_fin    = sx_next;
      sy_fin    = sy_next;
      deg_fin   = deg_next;
      spd_fin   = spd_next;
      ratio_fin = ratio_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= kevt_pkg::PhHeader;
      byte_count    <= '0;
      record_type   <= 8'd0;
      bytes_left    <= 8'd0;
      low_hold      <= 8'd0;
      frame_error   <= kevt_pkg::FailNone;
      current_event <= kevt_pkg::EventNone;
      stick_x       <= 16'd0;
      stick_y       <= 16'd0;
      wheel_degree  <= 16'd0;
      wheel_speed   <= 16'd0;
      wheel_ratio   <= 8'd0;
      keep_event    <= kevt_pkg::EventNone;
      keep_sx       <= 16'd0;
      keep_sy       <= 16'd0;
      keep_deg      <= 16'd0;
      keep_spd      <= 16'd0;
      keep_ratio    <= 8'd0;
    end else if (take) begin
      if (byte_count == '0) begin
        keep_event <= current_event;
        keep_sx    <= stick_x;
        keep_sy    <= stick_y;
        keep_deg   <= wheel_degree;
        keep_spd   <= wheel_speed;
        keep_ratio <= wheel_ratio;
      end
      current_event <= event_fin;
      stick_x       <= sx_fin;
      stick_y       <= sy_fin;
      wheel_degree  <= deg_fin;
      wheel_speed   <= spd_fin;
      wheel_ratio   <= ratio_fin;
      if (frame.last_byte) begin
        phase       <= kevt_pkg::PhHeader;
        byte_count  <= '0;
        record_type <= 8'd0;
        bytes_left  <= 8'd0;
        low_hold    <= 8'd0;
        frame_error <= kevt_pkg::FailNone;
      end else begin
        phase       <= phase_next;
        byte_count  <= count_next;
        record_type <= type_next;
        bytes_left  <= left_next;
        low_hold    <= hold_next;
        frame_error <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (take && frame.last_byte) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame.last_byte) begin
      report.parse_ok          <= (fail == kevt_pkg::FailNone);
      report.fail_code         <= fail;
      report.event_code        <= event_fin;
      report.stick_x           <= sx_fin;
      report.stick_y           <= sy_fin;
      report.wheel_degree      <= deg_fin;
      report.wheel_speed       <= spd_fin;
      report.wheel_speed_ratio <= ratio_fin;
    end
  end

  `KEVT_ASSERT_NOW(a_ok_matches_code, report.valid, report.parse_ok == (report.fail_code == kevt_pkg::FailNone), "parse_ok disagrees with fail_code")
  `KEVT_ASSERT_NEXT(a_last_gives_report, take && frame.last_byte, report.valid, "no report after last byte")
  `KEVT_ASSERT_NEXT(a_last_clears_parse, take && frame.last_byte, phase == kevt_pkg::PhHeader && byte_count == '0, "parser not cleared after frame")
  `KEVT_ASSERT_NOW(a_no_overrun, report.valid && !report.ready, !frame.ready, "byte taken while report stalled")

endmodule
